FILE: src/sbpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor beacon payload encoder package
// Shared types and constants: payload layout, object ids, scaled values.
// ----------------------------------------------------------------------------
package sbpe_pkg;

  localparam int unsigned PAYLOAD_BYTES = 18;
  localparam int unsigned BYTE_IDX_W    = $clog2(PAYLOAD_BYTES);

  localparam logic [7:0] DEVICE_INFO    = 8'h40;
  localparam logic [7:0] ID_PACKET      = 8'h00;
  localparam logic [7:0] ID_BATTERY     = 8'h01;
  localparam logic [7:0] ID_TEMPERATURE = 8'h02;
  localparam logic [7:0] ID_HUMIDITY    = 8'h03;
  localparam logic [7:0] ID_ILLUMINANCE = 8'h05;
  localparam logic [7:0] ID_VOLTAGE     = 8'h0C;

  localparam logic [7:0] BATT_FULL = 8'd100;

  typedef struct packed {
    logic [7:0]  battery;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [23:0] light;
    logic [15:0] voltage;
  } sbpe_values_t;

endpackage
`default_nettype wire

FILE: src/sbpe_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Measurement scaling
// Rounds and saturates the raw measurement into beacon units and derives
// the battery percentage from the supply voltage discharge curve.
// ----------------------------------------------------------------------------
module sbpe_scale (
  input  logic signed [31:0]   temperature_mdeg_i,
  input  logic [31:0]          humidity_mpct_i,
  input  logic [31:0]          light_lux_i,
  input  logic [31:0]          supply_mv_i,
  output sbpe_pkg::sbpe_values_t values_o
);
  import sbpe_pkg::*;

  // x / 10 == (x * RECIP10) >> RECIP_SH, exact for x < 2**22
  localparam logic [19:0] RECIP10  = 20'd838861;
  localparam int unsigned RECIP_SH = 23;

  localparam logic signed [31:0] TEMP_HI_MDEG = 32'sd327675;
  localparam logic signed [31:0] TEMP_LO_MDEG = -32'sd327685;
  localparam logic [31:0]        HUM_HI_MPCT  = 32'd655355;
  localparam logic [31:0]        LUX_HI       = 32'd167772;
  localparam logic [23:0]        LUX_SCALE    = 24'd100;
  localparam logic [23:0]        LUX_SAT      = 24'hFFFFFF;

  localparam int unsigned CURVE_POINTS = 9;
  localparam logic [11:0] CURVE_MV [CURVE_POINTS] = '{
    12'd3050, 12'd3000, 12'd2950, 12'd2900, 12'd2850,
    12'd2800, 12'd2700, 12'd2600, 12'd2400
  };
  localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd75, 7'd60, 7'd45, 7'd30, 7'd15, 7'd5, 7'd0
  };

  // temperature
  logic        t_neg, t_hi, t_lo;
  logic [20:0] t_abs, t_rnd;
  logic [40:0] t_prod;
  logic [15:0] t_mag, t_val;

  assign t_neg  = temperature_mdeg_i[31];
  assign t_hi   = temperature_mdeg_i >= TEMP_HI_MDEG;
  assign t_lo   = temperature_mdeg_i <= TEMP_LO_MDEG;
  assign t_abs  = t_neg ? (21'd0 - temperature_mdeg_i[20:0]) : temperature_mdeg_i[20:0];
  assign t_rnd  = t_abs + 21'd5;
  assign t_prod = t_rnd * RECIP10;
  assign t_mag  = t_prod[RECIP_SH+15:RECIP_SH];

  always_comb begin
    if (t_hi) begin
      t_val = 16'h7FFF;
    end else if (t_lo) begin
      t_val = 16'h8000;
    end else if (t_neg) begin
      t_val = 16'd0 - t_mag;
    end else begin
      t_val = t_mag;
    end
  end

  // humidity
  logic        h_sat;
  logic [19:0] h_rnd;
  logic [39:0] h_prod;

  assign h_sat  = humidity_mpct_i >= HUM_HI_MPCT;
  assign h_rnd  = humidity_mpct_i[19:0] + 20'd5;
  assign h_prod = h_rnd * RECIP10;

  // illuminance
  logic [23:0] l_val;
  assign l_val = (light_lux_i > LUX_HI) ? LUX_SAT : {6'd0, light_lux_i[17:0]} * LUX_SCALE;

  // battery
  logic        b_full, b_empty;
  logic [11:0] b_mv, b_lo_mv, b_hi_mv, b_diff, b_num, b_smv;
  logic [6:0]  b_lo_pct, b_hi_pct;
  logic [3:0]  b_spc;
  logic [14:0] b_ge;
  logic [3:0]  b_frac;
  logic [7:0]  b_val;

  assign b_full  = supply_mv_i >= 32'(CURVE_MV[0]);
  assign b_empty = supply_mv_i < 32'(CURVE_MV[CURVE_POINTS-1]);
  assign b_mv    = supply_mv_i[11:0];

  always_comb begin
    b_lo_mv  = CURVE_MV[CURVE_POINTS-1];
    b_hi_mv  = CURVE_MV[CURVE_POINTS-2];
    b_lo_pct = CURVE_PCT[CURVE_POINTS-1];
    b_hi_pct = CURVE_PCT[CURVE_POINTS-2];
    for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
      if (b_mv >= CURVE_MV[k]) begin
        b_lo_mv  = CURVE_MV[k];
        b_hi_mv  = CURVE_MV[k-1];
        b_lo_pct = CURVE_PCT[k];
        b_hi_pct = CURVE_PCT[k-1];
      end
    end
  end

  assign b_smv  = b_hi_mv - b_lo_mv;
  assign b_spc  = 4'(b_hi_pct - b_lo_pct);
  assign b_diff = b_mv - b_lo_mv;
  assign b_num  = b_diff[7:0] * b_spc + {1'b0, b_smv[11:1]};

  always_comb begin
    for (int j = 1; j <= 15; j++) begin
      b_ge[j-1] = b_num >= 12'(j) * b_smv;
    end
  end

  assign b_frac = 4'($countones(b_ge));

  always_comb begin
    if (b_full) begin
      b_val = BATT_FULL;
    end else if (b_empty) begin
      b_val = 8'd0;
    end else begin
      b_val = {1'b0, b_lo_pct} + {4'd0, b_frac};
    end
  end

  assign values_o.battery     = b_val;
  assign values_o.temperature = t_val;
  assign values_o.humidity    = h_sat ? 16'hFFFF : h_prod[RECIP_SH+15:RECIP_SH];
  assign values_o.light       = l_val;
  assign values_o.voltage     = (|supply_mv_i[31:16]) ? 16'hFFFF : supply_mv_i[15:0];

endmodule
`default_nettype wire

FILE: src/sensor_beacon_payload_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor beacon payload encoder
// Turns one sensor measurement into an 18-byte beacon payload, sent one
// byte per transfer with a marker on the final byte.
//
// Input channel: one request carries temperature, humidity, illuminance and
// supply voltage; it is taken when in_valid_i is high and in_stall_o low.
// Output channel: payload_byte_o / last_byte_o, taken when out_valid_o is
// high and out_stall_i low. Bytes leave in payload order: device info, then
// id / value pairs, values little-endian.
// A taken request is held in the input register, then scaled into the frame
// register, from which its bytes are shown. The byte-wide output sets the rate:
// a next request is held in the input register while the current frame
// drains, and is scaled into the frame register as the last byte leaves.
// Reset clears the packet counter and all valid flags. While the receiver
// stalls the shown byte holds; once the input register is also full,
// in_stall_o rises.
// ----------------------------------------------------------------------------
module sensor_beacon_payload_encoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] temperature_mdeg_i,
  input  logic [31:0]        humidity_mpct_i,
  input  logic [31:0]        light_lux_i,
  input  logic [31:0]        supply_mv_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         payload_byte_o,
  output logic               last_byte_o
);
  import sbpe_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(PAYLOAD_BYTES - 1);

  // input register
  logic               in_valid_q, in_valid_d;
  logic signed [31:0] temp_q;
  logic [31:0]        hum_q, lux_q, mv_q;

  // frame register
  logic                  frame_valid_q, frame_valid_d;
  sbpe_values_t          values_q, values_d;
  logic [7:0]            pkt_q, pkt_d, pkt_cnt_q, pkt_cnt_d;
  logic [BYTE_IDX_W-1:0] idx_q, idx_d;

  logic in_take, out_take, frame_done, frame_load;

  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = frame_valid_q && !out_stall_i;
  assign frame_done = out_take && (idx_q == LAST_IDX);
  assign frame_load = in_valid_q && (!frame_valid_q || frame_done);
  assign in_stall_o = in_valid_q && !frame_load;

  sbpe_scale u_scale (
    .temperature_mdeg_i (temp_q),
    .humidity_mpct_i    (hum_q),
    .light_lux_i        (lux_q),
    .supply_mv_i        (mv_q),
    .values_o           (values_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (frame_load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    frame_valid_d = frame_valid_q;
    idx_d         = idx_q;
    pkt_cnt_d     = pkt_cnt_q;
    pkt_d         = pkt_q;
    if (frame_done) begin
      frame_valid_d = 1'b0;
      idx_d         = '0;
    end else if (out_take) begin
      idx_d = idx_q + 1'b1;
    end
    if (frame_load) begin
      frame_valid_d = 1'b1;
      pkt_d         = pkt_cnt_q;
      pkt_cnt_d     = pkt_cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
      pkt_cnt_q     <= 8'd0;
    end else begin
      in_valid_q    <= in_valid_d;
      frame_valid_q <= frame_valid_d;
      idx_q         <= idx_d;
      pkt_cnt_q     <= pkt_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      temp_q <= temperature_mdeg_i;
      hum_q  <= humidity_mpct_i;
      lux_q  <= light_lux_i;
      mv_q   <= supply_mv_i;
    end
    if (frame_load) begin
      values_q <= values_d;
    end
    pkt_q <= pkt_d;
  end

  always_comb begin
    case (idx_q)
      5'd0:    payload_byte_o = DEVICE_INFO;
      5'd1:    payload_byte_o = ID_PACKET;
      5'd2:    payload_byte_o = pkt_q;
      5'd3:    payload_byte_o = ID_BATTERY;
      5'd4:    payload_byte_o = values_q.battery;
      5'd5:    payload_byte_o = ID_TEMPERATURE;
      5'd6:    payload_byte_o = values_q.temperature[7:0];
      5'd7:    payload_byte_o = values_q.temperature[15:8];
      5'd8:    payload_byte_o = ID_HUMIDITY;
      5'd9:    payload_byte_o = values_q.humidity[7:0];
      5'd10:   payload_byte_o = values_q.humidity[15:8];
      5'd11:   payload_byte_o = ID_ILLUMINANCE;
      5'd12:   payload_byte_o = values_q.light[7:0];
      5'd13:   payload_byte_o = values_q.light[15:8];
      5'd14:   payload_byte_o = values_q.light[23:16];
      5'd15:   payload_byte_o = ID_VOLTAGE;
      5'd16:   payload_byte_o = values_q.voltage[7:0];
      5'd17:   payload_byte_o = values_q.voltage[15:8];
      default: payload_byte_o = 8'd0;
    endcase
  end

  assign out_valid_o = frame_valid_q;
  assign last_byte_o = idx_q == LAST_IDX;

endmodule
`default_nettype wire

FILE: src/sbpe_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor beacon payload encoder port checker
// Watches the top level ports: stall behaviour, frame framing, the opening
// device info byte and the battery bound of each payload.
// ----------------------------------------------------------------------------
module sbpe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic       last_byte_o
);
  import sbpe_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(PAYLOAD_BYTES - 1);
  localparam logic [BYTE_IDX_W-1:0] BATT_POS = BYTE_IDX_W'(4);

  logic [BYTE_IDX_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(last_byte_o))
    else $error("stalled output byte changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_byte_o == (cnt_q == LAST_IDX))
    else $error("last marker out of place");

  a_dev_info: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cnt_q == '0 |-> payload_byte_o == DEVICE_INFO)
    else $error("frame does not open with device info");

  a_batt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cnt_q == BATT_POS |-> payload_byte_o <= BATT_FULL)
    else $error("battery above full scale");

  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind sensor_beacon_payload_encoder_unit sbpe_checker u_sbpe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .last_byte_o    (last_byte_o)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor beacon payload encoder testbench
// Drives sensor measurements through the input channel and scores every
// payload byte against an in-bench encoder (scaling, saturation, battery
// curve, packet counter). Directed corner requests come first, then random
// requests with random gaps and receiver stalls in all but the middle batch, and drained pauses between.
// ----------------------------------------------------------------------------
module tb_top;
  import sbpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned BATT_TOP_MV   = 3050;
  localparam int unsigned BATT_FLOOR_MV = 2400;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        hum;
    logic [31:0]        lux;
    logic [31:0]        mv;
  } meas_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pbyte_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               in_valid_i         = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] temperature_mdeg_i = '0;
  logic [31:0]        humidity_mpct_i    = '0;
  logic [31:0]        light_lux_i        = '0;
  logic [31:0]        supply_mv_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i        = 1'b0;
  logic [7:0]         payload_byte_o;
  logic               last_byte_o;

  meas_t       meas_q[$];
  pbyte_t      frame_bytes_q[$];
  meas_t       tx_cur;
  logic        tx_busy    = 1'b0;
  int unsigned tx_gap     = 0;
  int unsigned rx_wait    = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  logic [7:0]  pkt_count  = '0;
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;

  sensor_beacon_payload_encoder_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .temperature_mdeg_i (temperature_mdeg_i),
    .humidity_mpct_i    (humidity_mpct_i),
    .light_lux_i        (light_lux_i),
    .supply_mv_i        (supply_mv_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .payload_byte_o     (payload_byte_o),
    .last_byte_o        (last_byte_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] batt_level(logic [31:0] mv);
    int unsigned hi_mv, lo_mv, hi_pc, lo_pc;
    if (mv >= BATT_TOP_MV) return BATT_FULL;
    if (mv < BATT_FLOOR_MV) return 8'd0;
    if (mv >= 3000) begin
      hi_mv = 3050; lo_mv = 3000; hi_pc = 100; lo_pc = 90;
    end else if (mv >= 2950) begin
      hi_mv = 3000; lo_mv = 2950; hi_pc = 90; lo_pc = 75;
    end else if (mv >= 2900) begin
      hi_mv = 2950; lo_mv = 2900; hi_pc = 75; lo_pc = 60;
    end else if (mv >= 2850) begin
      hi_mv = 2900; lo_mv = 2850; hi_pc = 60; lo_pc = 45;
    end else if (mv >= 2800) begin
      hi_mv = 2850; lo_mv = 2800; hi_pc = 45; lo_pc = 30;
    end else if (mv >= 2700) begin
      hi_mv = 2800; lo_mv = 2700; hi_pc = 30; lo_pc = 15;
    end else if (mv >= 2600) begin
      hi_mv = 2700; lo_mv = 2600; hi_pc = 15; lo_pc = 5;
    end else begin
      hi_mv = 2600; lo_mv = 2400; hi_pc = 5; lo_pc = 0;
    end
    return 8'(lo_pc + ((mv - lo_mv) * (hi_pc - lo_pc) + (hi_mv - lo_mv) / 2) / (hi_mv - lo_mv));
  endfunction

  // encodes one measurement into the frame bytes awaited on the output
  function automatic void encode_frame(meas_t m);
    longint     t, tc;
    logic [39:0] hc;
    logic [23:0] lc;
    logic [15:0] vc, tbits;
    logic [7:0]  b [PAYLOAD_BYTES];
    pbyte_t      pb;
    t = longint'($signed(m.temp));
    tc = (t >= 0) ? (t + 5) / 10 : (t - 5) / 10;
    if (tc > 32767) tc = 32767;
    else if (tc < -32768) tc = -32768;
    tbits = tc[15:0];
    hc = ({8'd0, m.hum} + 40'd5) / 40'd10;
    if (hc > 40'hFFFF) hc = 40'hFFFF;
    lc = (m.lux > 32'd167772) ? 24'hFFFFFF : m.lux[23:0] * 24'd100;
    vc = (m.mv > 32'hFFFF) ? 16'hFFFF : m.mv[15:0];
    b[0]  = DEVICE_INFO;
    b[1]  = ID_PACKET;
    b[2]  = pkt_count;
    b[3]  = ID_BATTERY;
    b[4]  = batt_level(m.mv);
    b[5]  = ID_TEMPERATURE;
    b[6]  = tbits[7:0];
    b[7]  = tbits[15:8];
    b[8]  = ID_HUMIDITY;
    b[9]  = hc[7:0];
    b[10] = hc[15:8];
    b[11] = ID_ILLUMINANCE;
    b[12] = lc[7:0];
    b[13] = lc[15:8];
    b[14] = lc[23:16];
    b[15] = ID_VOLTAGE;
    b[16] = vc[7:0];
    b[17] = vc[15:8];
    pkt_count = pkt_count + 8'd1;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      pb.data = b[k];
      pb.last = (k == PAYLOAD_BYTES - 1);
      frame_bytes_q.push_back(pb);
    end
  endfunction

  function automatic meas_t rand_meas();
    meas_t m;
    int    sel;
    sel = $urandom_range(0, 3);
    m.temp = $urandom();
    m.hum  = $urandom();
    m.lux  = $urandom();
    m.mv   = $urandom();
    if (sel == 1) begin
      m.temp = int'($urandom_range(0, 125000)) - 40000;
      m.hum  = $urandom_range(0, 100000);
      m.lux  = $urandom_range(0, 200000);
      m.mv   = $urandom_range(2300, 3150);
    end else if (sel == 2) begin
      m.temp = int'($urandom_range(0, 40)) + ($urandom_range(0, 1) ? 327650 : -327710);
      m.hum  = $urandom_range(655330, 655380);
      m.lux  = $urandom_range(167760, 167790);
      m.mv   = $urandom_range(0, 1) ? $urandom_range(65520, 65550) : $urandom_range(2390, 3060);
    end
    return m;
  endfunction

  function automatic void queue_meas(int signed t, int unsigned h, int unsigned l,
                                     int unsigned v);
    meas_t m;
    m.temp = t;
    m.hum  = h;
    m.lux  = l;
    m.mv   = v;
    meas_q.push_back(m);
  endfunction

  task automatic wait_drained();
    while (meas_q.size() != 0 || tx_busy || frame_bytes_q.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_busy = 1'b0;
      tx_gap  = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_frame(tx_cur);
        tx_busy = 1'b0;
        tx_gap  = tx_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (meas_q.size() != 0) begin
          tx_cur  = meas_q.pop_front();
          tx_busy = 1'b1;
          temperature_mdeg_i <= tx_cur.temp;
          humidity_mpct_i    <= tx_cur.hum;
          light_lux_i        <= tx_cur.lux;
          supply_mv_i        <= tx_cur.mv;
        end
      end
      in_valid_i <= tx_busy;
    end
  end

  // payload monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    pbyte_t pb;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          $error("payload_byte with no request pending: actual %0h", payload_byte_o);
          err_cnt++;
        end else begin
          pb = frame_bytes_q.pop_front();
          if (payload_byte_o !== pb.data) begin
            $error("payload_byte mismatch: expected %0h, actual %0h", pb.data, payload_byte_o);
            err_cnt++;
          end
          if (last_byte_o !== pb.last) begin
            $error("last_byte mismatch: expected %0b, actual %0b", pb.last, last_byte_o);
            err_cnt++;
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sensor_beacon_payload_encoder_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: rounding, saturation, battery curve points, wide extremes
    queue_meas(0, 0, 0, 0);
    queue_meas(32'sh7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_meas(32'sh80000000, 4, 167772, 65535);
    queue_meas(5, 5, 167773, 65536);
    queue_meas(4, 655354, 1, BATT_TOP_MV);
    queue_meas(-4, 655355, 167771, BATT_TOP_MV - 1);
    queue_meas(-5, 15, 2, 3000);
    queue_meas(-1, 14, 100000, 2975);
    queue_meas(327674, 999, 3, 2950);
    queue_meas(327675, 1000, 4, 2900);
    queue_meas(-327684, 24, 5, 2850);
    queue_meas(-327685, 25, 6, 2800);
    queue_meas(-15, 65535, 7, 2700);
    queue_meas(15, 65536, 8, 2600);
    queue_meas(-16, 100000, 9, 2500);
    queue_meas(1234, 45678, 10, BATT_FLOOR_MV);
    queue_meas(-40000, 12345, 11, BATT_FLOOR_MV - 1);
    queue_meas(85000, 99999, 12, 2650);
    queue_meas(32'sh55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
    queue_meas(32'shAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    queue_meas(-2147483647, 32'hFFFFFFFA, 32'h00FFFFFF, 2401);
    wait_drained();

    for (int i = 0; i < 109; i++) meas_q.push_back(rand_meas());
    wait_drained();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 70; i++) meas_q.push_back(rand_meas());
    wait_drained();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 70; i++) meas_q.push_back(rand_meas());
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sensor_beacon_payload_encoder_unit test passed");
    end else begin
      $display("sensor_beacon_payload_encoder_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sbpe_pkg.sv
src/sbpe_scale.sv
src/sensor_beacon_payload_encoder_unit.sv
src/sbpe_checker.sv
tb/sv/tb_top.sv
